/* rtl/mpet_pkg.sv */
// shared constants and codes for the mesh property extrema tracker
package mpet_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int VALUE_BITS_DEF = 24;

  localparam int OPCODE_W      = 2;
  localparam int STAT_W        = 3;
  localparam int NUM_STATS     = 7;
  localparam int NUM_MAX_STATS = 3;
  // fraction bits of the Q16.8 inputs
  localparam int IN_FRAC_BITS  = 8;

  localparam logic [OPCODE_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] SEL_MAX_VP    = 3'd0;
  localparam logic [STAT_W-1:0] SEL_MAX_VS    = 3'd1;
  localparam logic [STAT_W-1:0] SEL_MAX_RHO   = 3'd2;
  localparam logic [STAT_W-1:0] SEL_MIN_VP    = 3'd3;
  localparam logic [STAT_W-1:0] SEL_MIN_VS    = 3'd4;
  localparam logic [STAT_W-1:0] SEL_MIN_RHO   = 3'd5;
  localparam logic [STAT_W-1:0] SEL_MIN_RATIO = 3'd6;

endpackage

/* rtl/mesh_property_extrema_tracker_unit.sv */
// running min/max tracker of mesh properties with a restoring divider for vp/vs
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i, in_ready_o | opcode, coords, vp, vs, rho, stat_select
//   out     | output    | out_valid_o, out_ready_i | stat_id, stat_value, where_i/j/k
//
// one item at a time: a beat is taken only in the idle state
// sample with vs zero or a ratio above full scale: execute only; otherwise it goes on through
// the restoring divider, which makes one quotient bit per cycle, and then a ratio compare
// read or clear: execute only; a read waits in its execute state while the output register is full
// reset sets maxima to zero, minima to all ones and every location to zero
module mesh_property_extrema_tracker_unit #(
  parameter int COORD_BITS = mpet_pkg::COORD_BITS_DEF,
  parameter int VALUE_BITS = mpet_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mpet_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [COORD_BITS-1:0]         coord_i_i,
  input  logic [COORD_BITS-1:0]         coord_j_i,
  input  logic [COORD_BITS-1:0]         coord_k_i,
  input  logic [VALUE_BITS-1:0]         p_velocity_i,
  input  logic [VALUE_BITS-1:0]         s_velocity_i,
  input  logic [VALUE_BITS-1:0]         density_i,
  input  logic [mpet_pkg::STAT_W-1:0]   stat_select_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mpet_pkg::STAT_W-1:0]   stat_id_o,
  output logic [VALUE_BITS-1:0]         stat_value_o,
  output logic [COORD_BITS-1:0]         where_i_o,
  output logic [COORD_BITS-1:0]         where_j_o,
  output logic [COORD_BITS-1:0]         where_k_o
);

  localparam int NS    = mpet_pkg::NUM_STATS;
  localparam int SW    = mpet_pkg::STAT_W;
  localparam int FB    = mpet_pkg::IN_FRAC_BITS;
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_RCMP = 2'd3;

  logic [1:0] state_q, state_d;

  // captured item
  logic [mpet_pkg::OPCODE_W-1:0] op_q;
  logic [COORD_BITS-1:0]         ci_q, cj_q, ck_q;
  logic [VALUE_BITS-1:0]         vp_q, vs_q, rho_q;
  logic [SW-1:0]                 sel_q;

  // stored extremes
  logic [VALUE_BITS-1:0] ext_val_q [NS];
  logic [COORD_BITS-1:0] ext_i_q   [NS];
  logic [COORD_BITS-1:0] ext_j_q   [NS];
  logic [COORD_BITS-1:0] ext_k_q   [NS];

  // divider
  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [VALUE_BITS-1:0] dq_q, dq_d;
  logic [CNT_W-1:0]      cnt_q;
  logic [VALUE_BITS:0]   rem_sh, rem_sub;
  logic                  q_bit;
  logic                  ovf;

  // output register
  logic                  out_valid_q;
  logic [SW-1:0]         stat_id_q;
  logic [VALUE_BITS-1:0] stat_value_q;
  logic [COORD_BITS-1:0] where_i_q, where_j_q, where_k_q;

  logic                  in_acc;
  logic                  out_free;
  logic                  exec_sample, exec_read, exec_clear;
  logic                  sel_ok;
  logic [NS-1:0]         upd;
  logic [VALUE_BITS-1:0] nval [NS];

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign exec_sample = (state_q == ST_EXEC) && (op_q == mpet_pkg::OP_SAMPLE);
  assign exec_read   = (state_q == ST_EXEC) && (op_q == mpet_pkg::OP_READ);
  assign exec_clear  = (state_q == ST_EXEC) && (op_q == mpet_pkg::OP_CLEAR);
  assign sel_ok      = (sel_q < SW'(NS));

  // ratio overflows full scale when vp >= vs * 2^FB
  assign ovf = ({{FB{1'b0}}, vp_q} >= {vs_q, {FB{1'b0}}});

  // one restoring step
  assign rem_sh  = {rem_q, dq_q[VALUE_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, vs_q};
  assign q_bit   = (rem_sh >= {1'b0, vs_q});
  assign rem_d   = q_bit ? rem_sub[VALUE_BITS-1:0] : rem_sh[VALUE_BITS-1:0];
  assign dq_d    = {dq_q[VALUE_BITS-2:0], q_bit};

  always_comb begin
    upd = '0;
    nval[mpet_pkg::SEL_MAX_VP]    = vp_q;
    nval[mpet_pkg::SEL_MAX_VS]    = vs_q;
    nval[mpet_pkg::SEL_MAX_RHO]   = rho_q;
    nval[mpet_pkg::SEL_MIN_VP]    = vp_q;
    nval[mpet_pkg::SEL_MIN_VS]    = vs_q;
    nval[mpet_pkg::SEL_MIN_RHO]   = rho_q;
    nval[mpet_pkg::SEL_MIN_RATIO] = dq_q;
    if (exec_sample) begin
      upd[mpet_pkg::SEL_MAX_VP]  = vp_q  > ext_val_q[mpet_pkg::SEL_MAX_VP];
      upd[mpet_pkg::SEL_MAX_VS]  = vs_q  > ext_val_q[mpet_pkg::SEL_MAX_VS];
      upd[mpet_pkg::SEL_MAX_RHO] = rho_q > ext_val_q[mpet_pkg::SEL_MAX_RHO];
      upd[mpet_pkg::SEL_MIN_VP]  = vp_q  < ext_val_q[mpet_pkg::SEL_MIN_VP];
      upd[mpet_pkg::SEL_MIN_VS]  = vs_q  < ext_val_q[mpet_pkg::SEL_MIN_VS];
      upd[mpet_pkg::SEL_MIN_RHO] = rho_q < ext_val_q[mpet_pkg::SEL_MIN_RHO];
    end
    if (state_q == ST_RCMP) begin
      upd[mpet_pkg::SEL_MIN_RATIO] = dq_q < ext_val_q[mpet_pkg::SEL_MIN_RATIO];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_sample) begin
          state_d = (vs_q == '0 || ovf) ? ST_IDLE : ST_DIV;
        end else if (exec_read) begin
          if (!sel_ok || out_free) state_d = ST_IDLE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (cnt_q == CNT_W'(1)) state_d = ST_RCMP;
      end
      ST_RCMP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (exec_read && sel_ok && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (exec_sample) begin
        cnt_q <= CNT_W'(VALUE_BITS);
      end else if (state_q == ST_DIV) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= opcode_i;
      ci_q  <= coord_i_i;
      cj_q  <= coord_j_i;
      ck_q  <= coord_k_i;
      vp_q  <= p_velocity_i;
      vs_q  <= s_velocity_i;
      rho_q <= density_i;
      sel_q <= stat_select_i;
    end
    if (exec_sample) begin
      // start with the integer part of vp, then bring down its fraction and zeros
      rem_q <= {{FB{1'b0}}, vp_q[VALUE_BITS-1:FB]};
      dq_q  <= {vp_q[FB-1:0], {(VALUE_BITS-FB){1'b0}}};
    end else if (state_q == ST_DIV) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
    if (exec_read && sel_ok && out_free) begin
      stat_id_q    <= sel_q;
      stat_value_q <= ext_val_q[sel_q];
      where_i_q    <= ext_i_q[sel_q];
      where_j_q    <= ext_j_q[sel_q];
      where_k_q    <= ext_k_q[sel_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS; s++) begin
        ext_val_q[s] <= (s < mpet_pkg::NUM_MAX_STATS) ? {VALUE_BITS{1'b0}}
                                                      : {VALUE_BITS{1'b1}};
        ext_i_q[s]   <= '0;
        ext_j_q[s]   <= '0;
        ext_k_q[s]   <= '0;
      end
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (exec_clear) begin
          ext_val_q[s] <= (s < mpet_pkg::NUM_MAX_STATS) ? {VALUE_BITS{1'b0}}
                                                        : {VALUE_BITS{1'b1}};
          ext_i_q[s]   <= '0;
          ext_j_q[s]   <= '0;
          ext_k_q[s]   <= '0;
        end else if (upd[s]) begin
          ext_val_q[s] <= nval[s];
          ext_i_q[s]   <= ci_q;
          ext_j_q[s]   <= cj_q;
          ext_k_q[s]   <= ck_q;
        end
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign stat_id_o    = stat_id_q;
  assign stat_value_o = stat_value_q;
  assign where_i_o    = where_i_q;
  assign where_j_o    = where_j_q;
  assign where_k_o    = where_k_q;

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_EXEC))
    else $error("accepted beat did not enter execute");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < vs_q))
    else $error("divider remainder not below divisor");

  a_out_id_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (stat_id_o < SW'(NS)))
    else $error("result beat carries an unknown statistic");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q != '0))
    else $error("divider running with zero count");
`endif

endmodule
